[rtl/core/array_doubly_linked_list_top_assert.svh]
// assertion macros for the linked list block
`ifndef ARRAY_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH
`define ARRAY_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH

// property checked at every edge outside reset
`define ADLL_ASSERT_HOLD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition implies a consequence in the next cycle
`define ADLL_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

[rtl/core/adll_pkg.sv]
`timescale 1ns / 1ps

package adll_pkg;

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_DELETE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  localparam int SLOT_W = 4;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
  } result_t;

endpackage

[rtl/core/adll_ram.sv]
`timescale 1ns / 1ps

module adll_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wmask,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // bit-masked write port
  always_ff @(posedge clk) begin
    for (int b = 0; b < WIDTH; b++) begin
      if (we && wmask[b]) begin
        mem[waddr][b] <= wdata[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/adll_out.sv]
`timescale 1ns / 1ps

module adll_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  adll_pkg::result_t in_res,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,  // slot[3:0], zero fill
  output logic [1:0]        m_tuser   // status[1:0]
);

  adll_pkg::result_t held;

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= in_res;
    end
  end

  assign m_tdata = 8'(held.slot);
  assign m_tuser = held.status;

endmodule

[rtl/core/array_doubly_linked_list_top.sv]
`timescale 1ns / 1ps
// channel | direction | tvalid/tready     | payload
// s       | in        | s_tvalid/s_tready | tdata key_value[31:0], tuser func
// m       | out       | m_tvalid/m_tready | tdata slot[3:0], tuser status[1:0]
//
// append: A_WAIT then RESP to an empty list, A_WAIT, A_LINK, RESP otherwise; RESP hands off the result
// delete: D_WALK moves slot by slot up to the match, then D_FIX and RESP;
//   the walk is paced by the registered read of the link and key memories
// full and empty results come back without touching the memories
// reset is synchronous; no clearing pass, a fill count stands in for the free chain
// a stalled result waits in the output register while the next beat is taken

`include "array_doubly_linked_list_top_assert.svh"

module array_doubly_linked_list_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // key_value[31:0]
  input  logic [0:0]  s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // slot[3:0], zero fill
  output logic [1:0]  m_tuser   // status[1:0]
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int KW = 32;
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_A_WAIT = 6'b000010,
    ST_A_LINK = 6'b000100,
    ST_D_WALK = 6'b001000,
    ST_D_FIX  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t              state;
  logic [LW-1:0]       free_head;
  logic [LW-1:0]       list_head;
  logic [LW-1:0]       list_tail;
  logic [LW-1:0]       fill;
  logic [LW-1:0]       cur;
  logic [LW-1:0]       before_link;
  logic [LW-1:0]       after_link;
  logic [AW-1:0]       steps;
  logic signed [KW-1:0] key;
  adll_pkg::result_t   res;
  logic                res_ready;

  logic                nx_we;
  logic [LW-1:0]       nx_wlink;
  logic [LW-1:0]       nx_wdata;
  logic                nx_re;
  logic [LW-1:0]       nx_rlink;
  logic [LW-1:0]       nx_rdata;
  logic                nx_fresh;
  logic [LW-1:0]       nx_rd_link;
  logic [LW-1:0]       nx_link;

  logic                nd_we;
  logic [LW-1:0]       nd_wlink;
  logic [KW+LW-1:0]    nd_wmask;
  logic [KW+LW-1:0]    nd_wdata;
  logic                nd_re;
  logic [KW+LW-1:0]    nd_rdata;
  logic [KW-1:0]       nd_key;
  logic [LW-1:0]       nd_prev;

  logic                s_beat;
  logic                key_hit;
  logic                walk_end;

  assign s_tready = (state == ST_IDLE);
  assign s_beat   = s_tvalid && s_tready;

  // slots at or above the fill count were never taken: their link is the next slot
  assign nx_link  = nx_fresh ? LW'(nx_rd_link + LW'(1)) : nx_rdata;
  assign nd_key   = nd_rdata[KW+LW-1:LW];
  assign nd_prev  = nd_rdata[LW-1:0];
  assign key_hit  = (key == $signed(nd_key));
  assign walk_end = (nx_link == NIL) || (steps == AW'(DEPTH - 1));

  always_comb begin
    nx_we    = 1'b0;
    nx_wlink = cur;
    nx_wdata = NIL;
    nx_re    = 1'b0;
    nx_rlink = cur;
    nd_we    = 1'b0;
    nd_wlink = cur;
    nd_wmask = '1;
    nd_wdata = {key, NIL};
    nd_re    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_beat) begin
          if (adll_pkg::func_t'(s_tuser[0]) == adll_pkg::FUNC_APPEND) begin
            nx_re    = (free_head != NIL);
            nx_rlink = free_head;
          end else begin
            nx_re    = (list_head != NIL);
            nd_re    = (list_head != NIL);
            nx_rlink = list_head;
          end
        end
      end
      ST_A_WAIT: begin
        nx_we    = 1'b1;
        nx_wlink = cur;
        nx_wdata = NIL;
        nd_we    = 1'b1;
        nd_wlink = cur;
        nd_wdata = {key, (list_head == NIL) ? NIL : list_tail};
      end
      ST_A_LINK: begin
        nx_we    = 1'b1;
        nx_wlink = list_tail;
        nx_wdata = cur;
      end
      ST_D_WALK: begin
        if (key_hit) begin
          nx_we    = 1'b1;
          nx_wlink = cur;
          nx_wdata = free_head;
        end else if (!walk_end) begin
          nx_re    = 1'b1;
          nd_re    = 1'b1;
          nx_rlink = nx_link;
        end
      end
      ST_D_FIX: begin
        nx_we    = (before_link != NIL);
        nx_wlink = before_link;
        nx_wdata = after_link;
        nd_we    = (after_link != NIL);
        nd_wlink = after_link;
        nd_wmask = {{KW{1'b0}}, {LW{1'b1}}};
        nd_wdata = {{KW{1'b0}}, before_link};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_re) begin
      nx_fresh   <= (nx_rlink >= fill);
      nx_rd_link <= nx_rlink;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free_head <= '0;
      list_head <= NIL;
      list_tail <= NIL;
      fill      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_beat) begin
            key   <= $signed(s_tdata);
            steps <= '0;
            if (adll_pkg::func_t'(s_tuser[0]) == adll_pkg::FUNC_APPEND) begin
              cur <= free_head;
              if (free_head == NIL) begin
                res   <= '{status: adll_pkg::STATUS_FULL, slot: '0};
                state <= ST_RESP;
              end else begin
                state <= ST_A_WAIT;
              end
            end else begin
              cur <= list_head;
              if (list_head == NIL) begin
                res   <= '{status: adll_pkg::STATUS_EMPTY, slot: '0};
                state <= ST_RESP;
              end else begin
                state <= ST_D_WALK;
              end
            end
          end
        end
        ST_A_WAIT: begin
          free_head <= nx_link;
          if (cur == fill) begin
            fill <= LW'(fill + LW'(1));
          end
          res <= '{status: adll_pkg::STATUS_DONE, slot: adll_pkg::SLOT_W'(cur)};
          if (list_head == NIL) begin
            list_head <= cur;
            list_tail <= cur;
            state     <= ST_RESP;
          end else begin
            state <= ST_A_LINK;
          end
        end
        ST_A_LINK: begin
          list_tail <= cur;
          state     <= ST_RESP;
        end
        ST_D_WALK: begin
          if (key_hit) begin
            before_link <= nd_prev;
            after_link  <= nx_link;
            free_head   <= cur;
            state       <= ST_D_FIX;
          end else if (walk_end) begin
            res   <= '{status: adll_pkg::STATUS_NOT_FOUND, slot: '0};
            state <= ST_RESP;
          end else begin
            cur   <= nx_link;
            steps <= AW'(steps + AW'(1));
          end
        end
        ST_D_FIX: begin
          if (before_link == NIL) begin
            list_head <= after_link;
          end
          if (after_link == NIL) begin
            list_tail <= before_link;
          end
          res   <= '{status: adll_pkg::STATUS_DONE, slot: adll_pkg::SLOT_W'(cur)};
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  adll_ram #(
    .DEPTH (DEPTH),
    .WIDTH (LW)
  ) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_wlink[AW-1:0]),
    .wmask ({LW{1'b1}}),
    .wdata (nx_wdata),
    .re    (nx_re),
    .raddr (nx_rlink[AW-1:0]),
    .rdata (nx_rdata)
  );

  adll_ram #(
    .DEPTH (DEPTH),
    .WIDTH (KW + LW)
  ) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_wlink[AW-1:0]),
    .wmask (nd_wmask),
    .wdata (nd_wdata),
    .re    (nd_re),
    .raddr (nx_rlink[AW-1:0]),
    .rdata (nd_rdata)
  );

  adll_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (state == ST_RESP),
    .in_ready (res_ready),
    .in_res   (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `ADLL_ASSERT_HOLD(a_ends_agree, (state != ST_IDLE) || ((list_head == NIL) == (list_tail == NIL)), "list head and tail disagree on empty")
  `ADLL_ASSERT_HOLD(a_fill_bound, fill <= NIL, "fill count beyond depth")
  `ADLL_ASSERT_HOLD(a_full_means_filled, (state != ST_IDLE) || (free_head != NIL) || (fill == NIL), "free list empty before all slots were taken")
  `ADLL_ASSERT_HOLD(a_walk_in_range, (state != ST_D_WALK) || (cur != NIL), "walk reached the null link")
  `ADLL_ASSERT_NEXT(a_result_loaded, (state == ST_RESP) && res_ready, m_tvalid, "result not loaded into output register")

endmodule
